// ----- sv/ppu_rp_pkg.sv -----
// ---------------------------------------------------------------------------
// ppu_rp_pkg
// Shared widths, access modes and register numbers of the video unit's
// CPU register port.
// ---------------------------------------------------------------------------
package ppu_rp_pkg;

	localparam int SPRITE_DEPTH    = 256;
	localparam int SPR_IDX_BITS    = $clog2(SPRITE_DEPTH);
	localparam int VIDEO_ADDR_BITS = 14;

	// Field widths of one input item and one result item.
	localparam int MODE_W  = 2;
	localparam int REG_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int VADDR_W = 14;
	localparam int ACC_W   = 2;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 80;

	// Palette space starts at this video address.
	localparam logic [VIDEO_ADDR_BITS-1:0] PALETTE_START =
		VIDEO_ADDR_BITS'(16'h3F00);

	typedef enum logic [MODE_W-1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [ACC_W-1:0] {
		ACC_NONE  = 2'd0,
		ACC_READ  = 2'd1,
		ACC_WRITE = 2'd2
	} vram_acc_t;

	localparam logic [REG_W-1:0] REG_CTRL    = 3'd0;
	localparam logic [REG_W-1:0] REG_MASK    = 3'd1;
	localparam logic [REG_W-1:0] REG_STATUS  = 3'd2;
	localparam logic [REG_W-1:0] REG_SPR_ADR = 3'd3;
	localparam logic [REG_W-1:0] REG_SPR_DAT = 3'd4;
	localparam logic [REG_W-1:0] REG_SCROLL  = 3'd5;
	localparam logic [REG_W-1:0] REG_ADDR    = 3'd6;
	localparam logic [REG_W-1:0] REG_DATA    = 3'd7;

	localparam int CTRL_INC32_BIT = 2;
	localparam int STATUS_VBL_BIT = 7;

endpackage

// ----- sv/ppu_register_port.sv -----
// ---------------------------------------------------------------------------
// ppu_register_port
// CPU-facing eight-register window of a video unit, with sprite memory.
// ---------------------------------------------------------------------------
// Each item on the slave stream is one CPU access to the register window
// (read or write, selected by s_tuser) or a status byte loaded by the
// renderer. Each item yields exactly one result item on the master stream:
// the byte returned to the CPU, the video memory access to perform (kind in
// m_tuser, address and byte in m_tdata), the video address after the access
// and the current control, mask and scroll registers for the renderer.
//
// An accepted item is held in the input register, where the register
// updates and the sprite memory access take place; the result is then
// loaded into the output register. One item per cycle is sustained while
// the receiver does not stall.
// The sprite memory read port is registered alongside the output register.
//
// Reset clears only the valid flags and architectural registers; sprite
// memory is undefined until written. When the receiver stalls, the result
// stays in the output register and the item behind it in the input
// register; s_tready falls only while both are occupied and stalled.
// ---------------------------------------------------------------------------
module ppu_register_port (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] reg_index, [10:3] write_data, [18:11] vram_read_data, rest zero
	input  logic [ppu_rp_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] mode
	input  logic [ppu_rp_pkg::MODE_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] read_data, [21:8] vram_access_addr, [29:22] vram_write_byte,
	// [43:30] next_vram_addr, [51:44] ctrl_value, [59:52] mask_value,
	// [67:60] scroll_x, [75:68] scroll_y, rest zero
	output logic [ppu_rp_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] vram_access
	output logic [ppu_rp_pkg::ACC_W-1:0]     m_tuser
);
	import ppu_rp_pkg::*;

	// Input register.
	logic                     valid_s1;
	logic [MODE_W-1:0]        mode_s1;
	logic [REG_W-1:0]         reg_s1;
	logic [BYTE_W-1:0]        wdata_s1;
	logic [BYTE_W-1:0]        vdata_s1;

	// Architectural registers.
	logic [BYTE_W-1:0]          ctrl_q;
	logic [BYTE_W-1:0]          mask_q;
	logic [BYTE_W-1:0]          status_q;
	logic [BYTE_W-1:0]          spr_addr_q;
	logic [BYTE_W-1:0]          addr_hi_q;
	logic                       second_q;
	logic [BYTE_W-1:0]          scroll_x_q;
	logic [BYTE_W-1:0]          scroll_y_q;
	logic [VIDEO_ADDR_BITS-1:0] vaddr_q;
	logic [BYTE_W-1:0]          rbuf_q;

	// Sprite memory and its registered read port.
	logic [BYTE_W-1:0]       spr_mem [SPRITE_DEPTH];
	logic [BYTE_W-1:0]       spr_rdata_q;
	logic [SPR_IDX_BITS-1:0] spr_idx;
	logic                    spr_we;

	// Output register.
	logic                     out_valid_q;
	logic                     out_spr_q;
	logic [BYTE_W-1:0]        out_rd_q;
	logic [ACC_W-1:0]         out_acc_q;
	logic [VADDR_W-1:0]       out_acc_addr_q;
	logic [BYTE_W-1:0]        out_wbyte_q;
	logic [VADDR_W-1:0]       out_vaddr_q;
	logic [BYTE_W-1:0]        out_ctrl_q;
	logic [BYTE_W-1:0]        out_mask_q;
	logic [BYTE_W-1:0]        out_sx_q;
	logic [BYTE_W-1:0]        out_sy_q;

	// Next-state and result logic.
	logic                       advance;
	logic [BYTE_W-1:0]          ctrl_d, mask_d, status_d, spr_addr_d, addr_hi_d;
	logic                       second_d;
	logic [BYTE_W-1:0]          scroll_x_d, scroll_y_d, rbuf_d;
	logic [VIDEO_ADDR_BITS-1:0] vaddr_d, vaddr_step;
	logic [BYTE_W-1:0]          rd_d, wbyte_d;
	logic [ACC_W-1:0]           acc_d;
	logic [VIDEO_ADDR_BITS-1:0] acc_addr_d;
	logic                       spr_rd_d;
	logic                       palette;

	// The item in the input register moves on when the output register is
	// empty or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign spr_idx    = spr_addr_q[SPR_IDX_BITS-1:0];
	assign vaddr_step = ctrl_q[CTRL_INC32_BIT] ? VIDEO_ADDR_BITS'(32) : VIDEO_ADDR_BITS'(1);
	assign palette    = (vaddr_q >= PALETTE_START);

	always_comb begin
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		status_d   = status_q;
		spr_addr_d = spr_addr_q;
		addr_hi_d  = addr_hi_q;
		second_d   = second_q;
		scroll_x_d = scroll_x_q;
		scroll_y_d = scroll_y_q;
		vaddr_d    = vaddr_q;
		rbuf_d     = rbuf_q;
		rd_d       = '0;
		acc_d      = ACC_NONE;
		acc_addr_d = '0;
		wbyte_d    = '0;
		spr_rd_d   = 1'b0;
		spr_we     = 1'b0;
		unique case (mode_t'(mode_s1))
			MODE_READ: begin
				unique case (reg_s1)
					REG_STATUS: begin
						rd_d                     = status_q;
						addr_hi_d                = '0;
						second_d                 = 1'b0;
						status_d[STATUS_VBL_BIT] = 1'b0;
					end
					REG_SPR_DAT: begin
						spr_rd_d = 1'b1;
					end
					REG_DATA: begin
						acc_d      = ACC_READ;
						acc_addr_d = vaddr_q;
						// Palette reads bypass the one-byte read buffer.
						rd_d       = palette ? vdata_s1 : rbuf_q;
						rbuf_d     = vdata_s1;
						vaddr_d    = vaddr_q + vaddr_step;
					end
					default: begin
						rd_d = rbuf_q;
					end
				endcase
			end
			MODE_WRITE: begin
				unique case (reg_s1)
					REG_CTRL:    ctrl_d = wdata_s1;
					REG_MASK:    mask_d = wdata_s1;
					REG_SPR_ADR: spr_addr_d = wdata_s1;
					REG_SPR_DAT: begin
						spr_we     = valid_s1 && advance;
						spr_addr_d = spr_addr_q + BYTE_W'(1);
					end
					REG_SCROLL: begin
						if (second_q) begin
							scroll_y_d = wdata_s1;
						end else begin
							scroll_x_d = wdata_s1;
						end
						second_d = !second_q;
					end
					REG_ADDR: begin
						if (second_q) begin
							vaddr_d   = VIDEO_ADDR_BITS'({addr_hi_q, wdata_s1});
							addr_hi_d = '0;
						end else begin
							// The high byte also lands in the horizontal scroll.
							addr_hi_d  = wdata_s1;
							scroll_x_d = wdata_s1;
						end
						second_d = !second_q;
					end
					REG_DATA: begin
						acc_d      = ACC_WRITE;
						acc_addr_d = vaddr_q;
						wbyte_d    = wdata_s1;
						vaddr_d    = vaddr_q + vaddr_step;
					end
					default: ;
				endcase
			end
			MODE_STATUS: status_d = wdata_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ctrl_q      <= '0;
			mask_q      <= '0;
			status_q    <= '0;
			spr_addr_q  <= '0;
			addr_hi_q   <= '0;
			second_q    <= 1'b0;
			scroll_x_q  <= '0;
			scroll_y_q  <= '0;
			vaddr_q     <= '0;
			rbuf_q      <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				ctrl_q     <= ctrl_d;
				mask_q     <= mask_d;
				status_q   <= status_d;
				spr_addr_q <= spr_addr_d;
				addr_hi_q  <= addr_hi_d;
				second_q   <= second_d;
				scroll_x_q <= scroll_x_d;
				scroll_y_q <= scroll_y_d;
				vaddr_q    <= vaddr_d;
				rbuf_q     <= rbuf_d;
			end
		end
	end

	// Input and output payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser;
			reg_s1   <= s_tdata[2:0];
			wdata_s1 <= s_tdata[10:3];
			vdata_s1 <= s_tdata[18:11];
		end
		if (advance) begin
			out_spr_q      <= spr_rd_d;
			out_rd_q       <= rd_d;
			out_acc_q      <= acc_d;
			out_acc_addr_q <= VADDR_W'(acc_addr_d);
			out_wbyte_q    <= wbyte_d;
			out_vaddr_q    <= VADDR_W'(vaddr_d);
			out_ctrl_q     <= ctrl_d;
			out_mask_q     <= mask_d;
			out_sx_q       <= scroll_x_d;
			out_sy_q       <= scroll_y_d;
		end
	end

	// Sprite memory: at most one write and one read per item.
	always_ff @(posedge clk) begin
		if (spr_we) begin
			spr_mem[spr_idx] <= wdata_s1;
		end
		if (advance) begin
			spr_rdata_q <= spr_mem[spr_idx];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_acc_q;
	assign m_tdata  = {4'b0, out_sy_q, out_sx_q, out_mask_q, out_ctrl_q, out_vaddr_q,
		out_wbyte_q, out_acc_addr_q, (out_spr_q ? spr_rdata_q : out_rd_q)};

endmodule
